// File: rtl/core/encoder_speed_averager_macros.svh
// assertion macros used by the encoder speed averager top level
`ifndef ENCODER_SPEED_AVERAGER_MACROS_SVH
`define ENCODER_SPEED_AVERAGER_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define ESA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esa check failed");

// next-cycle implication, clocked on clk, quiet during reset
`define ESA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esa check failed");

`endif

// File: rtl/core/esa_pkg.sv
// shared types and constants of the encoder speed averager
package esa_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int HIST_AW = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = 32 + HIST_AW;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

	localparam logic [16:0] RELOAD_RST = 17'd20000;
	localparam logic [15:0] THRESH_RST = 16'd19000;
	localparam logic [23:0] SCALE_RST = 24'd65536;

	typedef struct packed {
		logic [15:0] counter_value;
		logic counting_down;
	} esa_in_t;

	typedef struct packed {
		logic signed [31:0] filtered_speed;
		logic signed [31:0] raw_speed;
		logic signed [31:0] total_count;
		logic direction;
	} esa_out_t;

	typedef struct packed {
		logic [16:0] reload_value;
		logic [15:0] wrap_threshold;
		logic [23:0] speed_scale;
	} esa_cfg_t;

	// pipeline control from the top level
	typedef struct packed {
		logic accept;
		logic adv;
		logic recalc;
		logic v_s3;
	} esa_ctl_t;

	typedef struct packed {
		logic signed [32:0] delta;
		logic [31:0] total;
		logic dir;
	} esa_s1_t;

	typedef struct packed {
		logic [39:0] prod_lo;
		logic signed [41:0] prod_hi;
		logic [31:0] total;
		logic dir;
	} esa_s2_t;

	typedef struct packed {
		logic signed [31:0] speed;
		logic [31:0] total;
		logic dir;
	} esa_s3_t;

endpackage

// File: rtl/core/esa_extend.sv
// wrap tracking, extended total and position delta
module esa_extend import esa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  esa_ctl_t ctl,
	input  esa_cfg_t cfg,
	input  esa_in_t  in_item,
	output esa_s1_t  s1
);

	logic [31:0] base_q;
	logic [15:0] wrap_q;
	logic [31:0] prev_q;
	esa_s1_t s1_q;

	logic [31:0] t0, t_up, t_dn, total_sel;
	logic [31:0] rl_x, wrap_adj, step_up, step_dn;
	logic signed [33:0] prev_x, cur_x, thr_x, d_raw;
	logic signed [33:0] base_prod;
	logic fwd, bwd;
	logic signed [32:0] delta;

	always_comb begin
		t0 = {16'd0, in_item.counter_value} + base_q;
		rl_x = {15'd0, cfg.reload_value};
		// crossing the signed limit of the wrap count takes 65536 reloads off the base step
		wrap_adj = {cfg.reload_value[15:0], 16'd0};
		step_up = (wrap_q == 16'h7FFF) ? rl_x - wrap_adj : rl_x;
		step_dn = (wrap_q == 16'h8000) ? rl_x - wrap_adj : rl_x;
		t_up = t0 + step_up;
		t_dn = t0 - step_dn;
		prev_x = {{2{prev_q[31]}}, prev_q};
		cur_x = {{2{t0[31]}}, t0};
		thr_x = {18'd0, cfg.wrap_threshold};
		d_raw = cur_x - prev_x;
		// forward wrap wins over backward
		fwd = (prev_x - cur_x) > thr_x;
		bwd = d_raw > thr_x;
		if (fwd) begin
			total_sel = t_up;
		end else if (bwd) begin
			total_sel = t_dn;
		end else begin
			total_sel = t0;
		end
		delta = $signed({total_sel[31], total_sel}) - $signed({prev_q[31], prev_q});
		base_prod = $signed(wrap_q) * $signed({1'b0, cfg.reload_value});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			wrap_q <= '0;
			prev_q <= '0;
		end else if (ctl.recalc) begin
			base_q <= base_prod[31:0];
		end else if (ctl.accept) begin
			prev_q <= total_sel;
			if (fwd) begin
				wrap_q <= wrap_q + 16'd1;
				base_q <= base_q + step_up;
			end else if (bwd) begin
				wrap_q <= wrap_q - 16'd1;
				base_q <= base_q - step_dn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			s1_q.delta <= delta;
			s1_q.total <= total_sel;
			s1_q.dir <= in_item.counting_down;
		end
	end

	assign s1 = s1_q;

endmodule

// File: rtl/core/esa_scale.sv
// split multiply of delta by the scale factor, q8 shift and saturation
module esa_scale import esa_pkg::*; (
	input  logic     clk,
	input  esa_ctl_t ctl,
	input  esa_cfg_t cfg,
	input  esa_s1_t  s1,
	output esa_s3_t  s3
);

	esa_s2_t s2_q;
	esa_s3_t s3_q;
	logic signed [57:0] prod;
	logic signed [31:0] speed;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			s2_q.prod_lo <= s1.delta[15:0] * cfg.speed_scale;
			s2_q.prod_hi <= $signed(s1.delta[32:16]) * $signed({1'b0, cfg.speed_scale});
			s2_q.total <= s1.total;
			s2_q.dir <= s1.dir;
		end
	end

	always_comb begin
		prod = $signed({s2_q.prod_hi, 16'd0}) + $signed({18'd0, s2_q.prod_lo});
		// floor by 256 is the arithmetic shift, then clamp to 32 bits
		if (prod[57:39] != {19{prod[57]}}) begin
			speed = prod[57] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			speed = prod[39:8];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			s3_q.speed <= speed;
			s3_q.total <= s2_q.total;
			s3_q.dir <= s2_q.dir;
		end
	end

	assign s3 = s3_q;

endmodule

// File: rtl/core/esa_average.sv
// running-sum moving average and result register
module esa_average import esa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  esa_ctl_t ctl,
	input  esa_s3_t  s3,
	output esa_out_t out_item
);

	logic signed [31:0] hist_q [HISTORY_DEPTH];
	logic [HIST_AW-1:0] ptr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_n;
	esa_out_t out_q;
	logic upd;

	assign upd = ctl.adv && ctl.v_s3;

	always_comb begin
		sum_n = sum_q - SUM_W'(hist_q[ptr_q]) + SUM_W'(s3.speed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (upd) begin
			hist_q[ptr_q] <= s3.speed;
			sum_q <= sum_n;
			if (ptr_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			out_q.filtered_speed <= sum_n[HIST_AW +: 32];
			out_q.raw_speed <= s3.speed;
			out_q.total_count <= s3.total;
			out_q.direction <= s3.dir;
		end
	end

	assign out_item = out_q;

endmodule

// File: rtl/core/encoder_speed_averager.sv
// top level of the encoder speed averager
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    esa_in_t  (counter, direction)
// out       output     out_valid / out_ready  esa_out_t (speeds, total, direction)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per clock when the result side keeps up; an accepted item reaches out_valid
// through four registers (wrap, multiply, saturate, average)
// the wrap tracking loop (compare, add, base update) sets the one-item-per-clock rate
// a write of reload_value holds in_ready low for one cycle while the wrap base
// wrap_count * reload_value is recomputed on its own multiplier
// reset clears the control and tracking state and the eight history entries at once: no clearing pass
// a stalled result freezes the whole pipeline; cfg_ready is always high
`include "encoder_speed_averager_macros.svh"

module encoder_speed_averager import esa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  esa_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output esa_out_t              out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	esa_cfg_t cfg_q;
	// base product needs refreshing after a reload write
	logic recalc_q;
	// stage valid bits
	logic v_s1, v_s2, v_s3, out_valid_q;

	logic adv;
	logic accept;
	logic cfg_wr;
	esa_ctl_t ctl;
	esa_s1_t s1;
	esa_s3_t s3;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	// the pipeline moves unless a finished item waits at the output
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv && !recalc_q;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign ctl.accept = accept;
	assign ctl.adv = adv;
	assign ctl.recalc = recalc_q;
	assign ctl.v_s3 = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reload_value <= RELOAD_RST;
			cfg_q.wrap_threshold <= THRESH_RST;
			cfg_q.speed_scale <= SCALE_RST;
			recalc_q <= 1'b0;
		end else begin
			recalc_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					CFG_RELOAD: begin
						cfg_q.reload_value <= cfg_data[16:0];
						recalc_q <= 1'b1;
					end
					CFG_THRESH: begin
						cfg_q.wrap_threshold <= cfg_data[15:0];
					end
					CFG_SCALE: begin
						cfg_q.speed_scale <= cfg_data[23:0];
					end
					default: begin
						// unknown index, write dropped
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	esa_extend u_extend (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg_q),
		.in_item (in_item),
		.s1      (s1)
	);

	esa_scale u_scale (
		.clk (clk),
		.ctl (ctl),
		.cfg (cfg_q),
		.s1  (s1),
		.s3  (s3)
	);

	esa_average u_average (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.s3       (s3),
		.out_item (out_item)
	);

	// a reload write blocks the next cycle's input while the base is rebuilt
	`ESA_ASSERT_NEXT(a_reload_blocks, cfg_wr && cfg_index == CFG_RELOAD, !in_ready)
	// a waiting result holds back new items
	`ESA_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)
	// an accepted item enters the first stage
	`ESA_ASSERT_NEXT(a_accept_s1, accept, v_s1)
	// the last stage lands in the result register when the pipeline moves
	`ESA_ASSERT_NEXT(a_s3_out, v_s3 && adv, out_valid)

endmodule

// File: test/tb_top.sv
// testbench for the encoder speed averager: predicted results checked item by item
`timescale 1ns / 100ps

module tb_top import esa_pkg::*; ();

	// register index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// cycles without any accepted item before the run is declared hung
	localparam int IDLE_LIMIT = 4000;
	// pipeline is four stages deep; idle clocks once the last owed result is back
	localparam int SETTLE_CYCLES = 20;
	localparam longint SPEED_MAX = 64'sd2147483647;
	localparam longint SPEED_MIN = -64'sd2147483648;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	esa_in_t               in_item;
	logic                  out_valid;
	logic                  out_ready;
	esa_out_t              out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the registers
	logic [16:0] m_reload;
	logic [15:0] m_thresh;
	logic [23:0] m_scale;

	// predictor copy of the position tracking and the averaging window
	logic signed [31:0] last_total;
	logic signed [15:0] wraps;
	int                 speed_ring [HISTORY_DEPTH];
	longint             ring_sum;
	int                 ring_head;

	// results still owed by the block, oldest first
	esa_out_t due_speeds [$];

	int fault_count;
	int send_idle_pct;
	int recv_stall_pct;
	int stall_cycles;

	encoder_speed_averager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// extended position from a raw count and the current wrap count
	function automatic logic [31:0] extend_count(logic [15:0] raw);
		longint t;
		t = longint'(raw) + longint'(wraps) * longint'(m_reload);
		return t[31:0];
	endfunction

	// one sample tick of the block: wrap tracking, scaled speed, moving average
	function automatic esa_out_t advance_encoder(esa_in_t tick_in);
		longint   prev;
		longint   cur;
		longint   spd;
		longint   avg;
		logic [31:0] total;
		esa_out_t r;
		total = extend_count(tick_in.counter_value);
		prev = longint'(last_total);
		cur = longint'(signed'(total));
		// jumps measured at full width, a drop (forward wrap) wins over a rise
		if (prev - cur > longint'(m_thresh)) begin
			wraps = wraps + 16'sd1;
			total = extend_count(tick_in.counter_value);
		end else if (cur - prev > longint'(m_thresh)) begin
			wraps = wraps - 16'sd1;
			total = extend_count(tick_in.counter_value);
		end
		cur = longint'(signed'(total));
		// q8 speed, floor division by 256, clamped to 32 bits
		spd = ((cur - prev) * longint'(m_scale)) >>> 8;
		if (spd > SPEED_MAX)
			spd = SPEED_MAX;
		if (spd < SPEED_MIN)
			spd = SPEED_MIN;
		ring_sum = ring_sum - longint'(speed_ring[ring_head]) + spd;
		speed_ring[ring_head] = int'(spd);
		ring_head = (ring_head + 1) % HISTORY_DEPTH;
		avg = ring_sum >>> HIST_AW;
		last_total = total;
		r.filtered_speed = avg[31:0];
		r.raw_speed = spd[31:0];
		r.total_count = total;
		r.direction = tick_in.counting_down;
		return r;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_fault($sformatf("%s: got %0d (%h) expected %0d (%h)", name,
				$signed(got), got, $signed(want), want));
	endtask

	// send one item, with a random idle gap in front of it
	task automatic feed_sample(input logic [15:0] counter, input logic down);
		esa_in_t tick_in;
		int      gap;
		tick_in.counter_value = counter;
		tick_in.counting_down = down;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= tick_in;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due_speeds.push_back(advance_encoder(tick_in));
	endtask

	// stop sending and wait until every owed result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_speeds.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no drop in between
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_RELOAD: begin
				m_reload = data[16:0];
			end
			CFG_THRESH: begin
				m_thresh = data[15:0];
			end
			CFG_SCALE: begin
				m_scale = data[23:0];
			end
			default: begin
			end
		endcase
	endtask

	// registers only change with the pipeline empty
	task automatic program_regs(input logic [CFG_DATA_W-1:0] reload,
			input logic [CFG_DATA_W-1:0] thresh, input logic [CFG_DATA_W-1:0] scale);
		settle();
		write_reg(CFG_RELOAD, reload);
		write_reg(CFG_THRESH, thresh);
		write_reg(CFG_SCALE, scale);
		cfg_valid <= 1'b0;
	endtask

	// reset values: backward wrap, forward wrap, rise of exactly the threshold
	// and one just above it, plus alternating bit patterns in the count
	task automatic test_wrap_tracking();
		feed_sample(16'h0000, 1'b0);
		feed_sample(16'hFFFF, 1'b1);
		feed_sample(16'hFFFF, 1'b1);
		feed_sample(16'h0000, 1'b0);
		feed_sample(16'd19000, 1'b0);
		feed_sample(16'd38001, 1'b0);
		feed_sample(16'hAAAA, 1'b1);
		feed_sample(16'h5555, 1'b0);
		feed_sample(16'h0001, 1'b0);
	endtask

	// widest threshold and largest scale push the speed into both clamps
	task automatic test_speed_saturation();
		program_regs(24'h010000, 24'h00FFFF, 24'hFFFFFF);
		feed_sample(16'h0000, 1'b0);
		feed_sample(16'hFFFF, 1'b0);
		feed_sample(16'h0000, 1'b1);
		feed_sample(16'hFFFF, 1'b1);
		feed_sample(16'h8000, 1'b0);
	endtask

	// zero reload, threshold and scale; the spare index; all-ones data truncated
	task automatic test_register_edges();
		program_regs(24'h000000, 24'h000000, 24'h000000);
		feed_sample(16'd100, 1'b0);
		feed_sample(16'd50, 1'b1);
		feed_sample(16'd200, 1'b0);
		settle();
		write_reg(CFG_SPARE, 24'hFFFFFF);
		cfg_valid <= 1'b0;
		feed_sample(16'd200, 1'b0);
		feed_sample(16'd7, 1'b1);
		program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		feed_sample(16'd1234, 1'b0);
		feed_sample(16'h0000, 1'b1);
	endtask

	// steady forward rotation with the widest reload, one wrap every three items,
	// then backward rotation so the wrap count climbs and falls again
	task automatic test_wrap_run();
		program_regs(24'h01FFFF, 24'd40000, 24'd256);
		for (int turn = 0; turn < 60; turn++) begin
			for (int k = 0; k < 3; k++) begin
				feed_sample((k == 2) ? 16'hFFFF : 16'(k * 32768), 1'($urandom));
			end
		end
		for (int turn = 0; turn < 40; turn++) begin
			for (int k = 0; k < 3; k++) begin
				feed_sample((k == 0) ? 16'hFFFF : 16'((2 - k) * 32768), 1'($urandom));
			end
		end
		repeat (4) begin
			feed_sample(16'h0000, 1'b0);
			feed_sample(16'h8000, 1'b0);
			feed_sample(16'hFFFF, 1'b0);
		end
	endtask

	// mostly a plausible encoder walk within one reload period, with steps the
	// wrap tracker should follow, and some items of pure noise in between
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int reload, input int thresh, input logic [23:0] scale,
			input int n_items, input bit pause_midway);
		int period;
		int reach;
		int pos;
		int stride;
		logic [15:0] counter;
		logic down;
		program_regs(24'(reload), 24'(thresh), scale);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		period = (m_reload == 17'd0 || m_reload > 17'd65536) ? 65536 : int'(m_reload);
		reach = (period / 2 < int'(m_thresh)) ? period / 2 : int'(m_thresh);
		pos = $urandom_range(0, period - 1);
		for (int i = 0; i < n_items; i++) begin
			if (pause_midway && i == n_items / 2)
				settle();
			if ($urandom_range(99) < 85) begin
				stride = $urandom_range(0, reach);
				down = 1'($urandom_range(1));
				if (down)
					stride = -stride;
				pos = ((pos + stride) % period + period) % period;
				counter = pos[15:0];
			end else begin
				counter = 16'($urandom);
				down = 1'($urandom);
			end
			feed_sample(counter, down);
		end
	endtask

	// result side: random back-pressure, compare each result with the oldest owed
	always @(posedge clk) begin : result_side
		esa_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (due_speeds.size() == 0) begin
					note_fault("result item with nothing outstanding");
				end else begin
					want = due_speeds.pop_front();
					check_field("filtered_speed", out_item.filtered_speed, want.filtered_speed);
					check_field("raw_speed", out_item.raw_speed, want.raw_speed);
					check_field("total_count", out_item.total_count, want.total_count);
					check_field("direction", 32'(out_item.direction), 32'(want.direction));
				end
			end
		end
	end

	// hang guard: any accepted item on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("FAIL encoder_speed_averager");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RELOAD;
		cfg_data = '0;
		fault_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		m_reload = RELOAD_RST;
		m_thresh = THRESH_RST;
		m_scale = SCALE_RST;
		last_total = '0;
		wraps = '0;
		ring_sum = 0;
		ring_head = 0;
		for (int i = 0; i < HISTORY_DEPTH; i++)
			speed_ring[i] = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wrap_tracking();
		test_speed_saturation();
		test_register_edges();
		test_wrap_run();

		// idling phases: none, sender mostly idle, receiver mostly stalled, both
		test_random_traffic(0, 0, 65536, 65535, 24'($urandom), 280, 1'b0);
		test_random_traffic(78, 0, 1, 1, 24'hFFFFFF, 280, 1'b0);
		test_random_traffic(0, 78, $urandom_range(1, 65536), $urandom_range(1, 65535),
			24'($urandom), 280, 1'b1);
		test_random_traffic(29, 29, $urandom_range(1, 65536), $urandom_range(1, 65535),
			24'h000000, 280, 1'b0);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && due_speeds.size() == 0) begin
			$display("PASS encoder_speed_averager");
		end else begin
			$display("FAIL encoder_speed_averager");
		end
		$finish;
	end

endmodule
